// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the comparator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define MMEC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define MMEC_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error(msg);

`else

`define MMEC_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define MMEC_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

// ===== rtl/mmec_pkg.sv =====
// ----------------------------------------------------------------------------
// mmec_pkg
// Types, codes and bus layout shared by the multi-mode entry comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmec_pkg;

    localparam int ATTR_COUNT_DEF = 4;
    localparam int ATTR_W         = 32;
    localparam int KEY_W          = 32;

    // Input tdata layout, lowest bit first.
    localparam int IN_INCL_LSB    = 0;
    localparam int IN_JOIN_LSB    = 1;
    localparam int IN_SRC_LSB     = IN_JOIN_LSB + KEY_W;
    localparam int IN_ALIGN_LSB   = IN_SRC_LSB + KEY_W;
    localparam int IN_DEST_LSB    = IN_ALIGN_LSB + KEY_W;
    localparam int IN_ATTR_LSB    = IN_DEST_LSB + KEY_W;
    localparam int IN_ATTR_ALL_W  = 4 * ATTR_W;
    localparam int IN_USED_W      = IN_ATTR_LSB + IN_ATTR_ALL_W;
    localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W     = 4;
    localparam int OUT_TDATA_W    = 8;

    typedef enum logic [2:0] {
        MODE_JOIN_PREC  = 3'd0,
        MODE_PAIRWISE   = 3'd1,
        MODE_END_FIRST  = 3'd2,
        MODE_JOIN_ATTR  = 3'd3,
        MODE_INDEX      = 3'd4,
        MODE_ALIGN      = 3'd5,
        MODE_PAD_LAST   = 3'd6,
        MODE_DEST       = 3'd7
    } mode_t;

    localparam logic [2:0] KIND_SOURCE   = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_END      = 3'd2;
    localparam logic [2:0] KIND_SORT_PAD = 3'd3;
    localparam logic [2:0] KIND_DIST_PAD = 3'd4;

    localparam logic POS_HOLD    = 1'b0;
    localparam logic POS_COMPARE = 1'b1;

    typedef struct packed {
        logic [2:0]              kind;
        logic                    incl;
        logic signed [KEY_W-1:0] join_key;
        logic signed [KEY_W-1:0] src_index;
        logic signed [KEY_W-1:0] align_key;
        logic signed [KEY_W-1:0] dest_index;
    } entry_t;

    // Boundary precedence rank used by the join ordering.
    function automatic logic [1:0] precedence(input logic [2:0] kind, input logic incl);
        logic [1:0] rank;
        begin
            case (kind)
                KIND_SOURCE: rank = 2'd2;
                KIND_START:  rank = incl ? 2'd1 : 2'd3;
                KIND_END:    rank = incl ? 2'd3 : 2'd1;
                default:     rank = 2'd0;
            endcase
            return rank;
        end
    endfunction

endpackage

// ===== rtl/multi_mode_entry_comparator.sv =====
// ----------------------------------------------------------------------------
// multi_mode_entry_comparator
// Holds the first entry of each pair and reports whether it sorts strictly
// before the second entry under the selected ordering mode.
//
// Channel   Dir  Signals                                   Transfer when
// s_axis    in   tvalid tready tdata[263:0] tuser[3:0]     tvalid && tready
// m_axis    out  tvalid tready tdata[7:0]                  tvalid && tready
// cfg       in   valid ready data[2:0]                     valid && ready
//
// One entry is accepted per cycle while s_axis_tready is high. A compare
// entry yields its result through the input register and then the result
// register. A hold entry yields nothing. When the result register is
// stalled, a compare entry waiting in the input register stops s_axis_tready.
// Reset clears the valid flags and sets the mode to join with precedence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_mode_entry_comparator
    import mmec_pkg::*;
#(
    parameter int ATTRIBUTE_COUNT = ATTR_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, low to high: boundary_inclusive, join_key, source_index,
    // align_key, dest_index, attributes_low_pair, attributes_high_pair, zeros.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser, low to high: pair_position, entry_kind.
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata, low to high: first_less, zeros.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data
);

    localparam int AW = ATTRIBUTE_COUNT * ATTR_W;

    mode_t          mode_reg;

    logic           st1_valid_reg;
    logic           st1_pos_reg;
    entry_t         st1_entry_reg;
    logic [AW-1:0]  st1_attr_reg;

    entry_t         held_reg;
    logic [AW-1:0]  held_attr_reg;

    logic           out_valid_reg;
    logic           out_less_reg;

    entry_t         in_entry;
    logic           s_xfer;
    logic           out_free;
    logic           st1_advance;
    logic           st1_hold;
    logic           cmp_less;

    assign in_entry.kind       = s_axis_tuser[3:1];
    assign in_entry.incl       = s_axis_tdata[IN_INCL_LSB];
    assign in_entry.join_key   = s_axis_tdata[IN_JOIN_LSB +: KEY_W];
    assign in_entry.src_index  = s_axis_tdata[IN_SRC_LSB +: KEY_W];
    assign in_entry.align_key  = s_axis_tdata[IN_ALIGN_LSB +: KEY_W];
    assign in_entry.dest_index = s_axis_tdata[IN_DEST_LSB +: KEY_W];

    assign st1_hold    = st1_pos_reg == POS_HOLD;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign st1_advance = st1_valid_reg && (st1_hold || out_free);

    assign s_axis_tready = !st1_valid_reg || st1_advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_JOIN_PREC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            st1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            st1_pos_reg   <= s_axis_tuser[0];
            st1_entry_reg <= in_entry;
            st1_attr_reg  <= s_axis_tdata[IN_ATTR_LSB +: AW];
        end
    end

    // The held entry is captured as the hold entry leaves the input register,
    // so every later compare entry sees it.
    always_ff @(posedge clk)
    begin
        if (st1_advance && st1_hold)
        begin
            held_reg      <= st1_entry_reg;
            held_attr_reg <= st1_attr_reg;
        end
    end

    mmec_order #(
        .ATTRIBUTE_COUNT (ATTRIBUTE_COUNT)
    ) u_order (
        .mode       (mode_reg),
        .held       (held_reg),
        .held_attr  (held_attr_reg),
        .cur        (st1_entry_reg),
        .cur_attr   (st1_attr_reg),
        .first_less (cmp_less)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= st1_valid_reg && !st1_hold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && st1_valid_reg && !st1_hold)
        begin
            out_less_reg <= cmp_less;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_less_reg};

    `MMEC_ASSERT(a_hold_no_result, clk, rst_n,
        (st1_valid_reg && st1_hold && !out_valid_reg) |=> !m_axis_tvalid,
        "A hold entry produced a result.")

    `MMEC_ASSERT(a_stall_blocks_input, clk, rst_n,
        (st1_valid_reg && !st1_hold && out_valid_reg && !m_axis_tready) |-> !s_axis_tready,
        "Input accepted while a compare entry was blocked by a stalled result.")

    `MMEC_ASSERT(a_held_capture, clk, rst_n,
        (st1_advance && st1_hold) |=> held_reg == $past(st1_entry_reg),
        "Held entry does not match the hold entry that passed.")

    `MMEC_NEVER(a_cmp_result_lost, clk, rst_n,
        st1_advance && !st1_hold && out_valid_reg && !m_axis_tready,
        "Compare result overwrote a result still waiting for transfer.")

endmodule

// ===== rtl/mmec_order.sv =====
// ----------------------------------------------------------------------------
// mmec_order
// Decides whether the held entry sorts strictly before the current one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmec_order
    import mmec_pkg::*;
#(
    parameter int ATTRIBUTE_COUNT = ATTR_COUNT_DEF
)
(
    input  mode_t                              mode,
    input  entry_t                             held,
    input  logic [ATTRIBUTE_COUNT*ATTR_W-1:0]  held_attr,
    input  entry_t                             cur,
    input  logic [ATTRIBUTE_COUNT*ATTR_W-1:0]  cur_attr,
    output logic                               first_less
);

    logic join_lt, join_eq, src_lt, src_eq, align_lt, dest_lt;
    logic prec_lt;
    logic [ATTRIBUTE_COUNT-1:0] attr_lt, attr_eq;
    logic attr_less;
    logic held_pad, cur_pad;
    logic held_tgt, cur_tgt, held_end, cur_end, held_dist, cur_dist;
    logic normal_less;

    assign join_lt  = held.join_key < cur.join_key;
    assign join_eq  = held.join_key == cur.join_key;
    assign src_lt   = held.src_index < cur.src_index;
    assign src_eq   = held.src_index == cur.src_index;
    assign align_lt = held.align_key < cur.align_key;
    assign dest_lt  = held.dest_index < cur.dest_index;
    assign prec_lt  = precedence(held.kind, held.incl) < precedence(cur.kind, cur.incl);

    always_comb
    begin
        for (int i = 0; i < ATTRIBUTE_COUNT; i++)
        begin
            attr_lt[i] = $signed(held_attr[i*ATTR_W +: ATTR_W])
                       < $signed(cur_attr[i*ATTR_W +: ATTR_W]);
            attr_eq[i] = held_attr[i*ATTR_W +: ATTR_W] == cur_attr[i*ATTR_W +: ATTR_W];
        end
    end

    // Lexicographic chain: the first attribute that differs decides.
    always_comb
    begin
        attr_less = 1'b0;
        for (int i = ATTRIBUTE_COUNT - 1; i >= 0; i--)
        begin
            attr_less = attr_lt[i] | (attr_eq[i] & attr_less);
        end
    end

    assign held_pad  = held.kind == KIND_SORT_PAD;
    assign cur_pad   = cur.kind == KIND_SORT_PAD;
    assign held_tgt  = (held.kind == KIND_START) || (held.kind == KIND_END);
    assign cur_tgt   = (cur.kind == KIND_START) || (cur.kind == KIND_END);
    assign held_end  = held.kind == KIND_END;
    assign cur_end   = cur.kind == KIND_END;
    assign held_dist = held.kind == KIND_DIST_PAD;
    assign cur_dist  = cur.kind == KIND_DIST_PAD;

    always_comb
    begin
        case (mode)
            MODE_JOIN_PREC:
                normal_less = join_lt | (join_eq & prec_lt);
            MODE_PAIRWISE:
                if (held_tgt != cur_tgt)
                    normal_less = held_tgt;
                else
                    normal_less = src_lt | (src_eq & (held.kind == KIND_START)
                                                   & (cur.kind != KIND_START));
            MODE_END_FIRST:
                normal_less = (held_end != cur_end) ? held_end : src_lt;
            MODE_JOIN_ATTR:
                normal_less = join_lt | (join_eq & attr_less);
            MODE_INDEX:
                normal_less = src_lt;
            MODE_ALIGN:
                normal_less = align_lt;
            MODE_PAD_LAST:
                normal_less = (held_dist != cur_dist) ? cur_dist : src_lt;
            MODE_DEST:
                normal_less = dest_lt;
            default:
                normal_less = dest_lt;
        endcase
    end

    // Sort padding goes after everything else in every mode.
    assign first_less = (held_pad != cur_pad) ? cur_pad : normal_less;

endmodule

// ===== test/multi_mode_entry_comparator_tb.sv =====
// ----------------------------------------------------------------------------
// multi_mode_entry_comparator_tb
// Streams hold and compare entries into the comparator under every ordering
// mode, predicts each first_less result in the bench, and checks the results
// in order. The sender works in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_mode_entry_comparator_tb
    import mmec_pkg::*;
();

    localparam int ATTR_USED    = 4;
    localparam int PHASE_ITEMS  = 43;
    localparam int SETTLE_TICKS = 4;
    localparam int IDLE_LIMIT   = 4000;

    localparam bit [31:0] KEY_MIN = 32'h8000_0000;
    localparam bit [31:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        bit             pos;
        bit [2:0]       kind;
        bit             incl;
        bit [31:0]      join_key;
        bit [31:0]      src_index;
        bit [31:0]      align_key;
        bit [31:0]      dest_index;
        bit [3:0][31:0] attr;
    } entry_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_data = '0;

    entry_item_t pending_entries[$];
    bit          expected_less[$];
    entry_item_t held_entry;
    entry_item_t gen_ref;
    entry_item_t drive_entry;
    mode_t       active_mode = MODE_JOIN_PREC;

    int items_queued   = 0;
    int items_accepted = 0;
    int hold_count     = 0;
    int compare_count  = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int mode_writes    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int idle_cycles    = 0;
    int stall_level    = 0;
    int stall_ticks    = 0;
    bit [7:0] modes_written = '0;

    always #5 clk = ~clk;

    multi_mode_entry_comparator #(
        .ATTRIBUTE_COUNT(ATTR_USED)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic int key_order(input bit [31:0] a, input bit [31:0] b);
        if ($signed(a) < $signed(b))
        begin
            return -1;
        end
        if ($signed(a) > $signed(b))
        begin
            return 1;
        end
        return 0;
    endfunction

    function automatic int boundary_rank(input bit [2:0] kind, input bit incl);
        if (kind == KIND_SOURCE)
        begin
            return 2;
        end
        if (kind == KIND_START)
        begin
            return incl ? 1 : 3;
        end
        if (kind == KIND_END)
        begin
            return incl ? 3 : 1;
        end
        return 0;
    endfunction

    function automatic int mode_order(input entry_item_t a, input entry_item_t b,
                                      input mode_t m);
        int c;
        int fa;
        int fb;
        c = 0;
        case (m)
            MODE_JOIN_PREC:
            begin
                c = key_order(a.join_key, b.join_key);
                if (c == 0)
                begin
                    c = key_order(boundary_rank(a.kind, a.incl), boundary_rank(b.kind, b.incl));
                end
            end
            MODE_PAIRWISE:
            begin
                fa = int'(a.kind == KIND_START || a.kind == KIND_END);
                fb = int'(b.kind == KIND_START || b.kind == KIND_END);
                if (fa != fb)
                begin
                    c = fb - fa;
                end
                else
                begin
                    c = key_order(a.src_index, b.src_index);
                    if (c == 0)
                    begin
                        c = int'(b.kind == KIND_START) - int'(a.kind == KIND_START);
                    end
                end
            end
            MODE_END_FIRST:
            begin
                fa = int'(a.kind == KIND_END);
                fb = int'(b.kind == KIND_END);
                c = (fa != fb) ? fb - fa : key_order(a.src_index, b.src_index);
            end
            MODE_JOIN_ATTR:
            begin
                c = key_order(a.join_key, b.join_key);
                for (int i = 0; i < ATTR_USED; i++)
                begin
                    if (c == 0)
                    begin
                        c = key_order(a.attr[i], b.attr[i]);
                    end
                end
            end
            MODE_INDEX:
            begin
                c = key_order(a.src_index, b.src_index);
            end
            MODE_ALIGN:
            begin
                c = key_order(a.align_key, b.align_key);
            end
            MODE_PAD_LAST:
            begin
                fa = int'(a.kind == KIND_DIST_PAD);
                fb = int'(b.kind == KIND_DIST_PAD);
                c = (fa != fb) ? fa - fb : key_order(a.src_index, b.src_index);
            end
            default:
            begin
                c = key_order(a.dest_index, b.dest_index);
            end
        endcase
        return c;
    endfunction

    // Sort padding goes behind everything else before the mode rule applies.
    function automatic bit first_sorts_before(input entry_item_t a, input entry_item_t b,
                                              input mode_t m);
        int pa;
        int pb;
        int c;
        pa = int'(a.kind == KIND_SORT_PAD);
        pb = int'(b.kind == KIND_SORT_PAD);
        c = (pa != pb) ? pa - pb : mode_order(a, b, m);
        return c < 0;
    endfunction

    task automatic track_entry(input entry_item_t e);
        if (e.pos == POS_HOLD)
        begin
            held_entry = e;
            hold_count++;
        end
        else
        begin
            expected_less.push_back(first_sorts_before(held_entry, e, active_mode));
            compare_count++;
        end
    endtask

    function automatic entry_item_t mk_entry(input bit pos, input bit [2:0] kind,
                                             input bit incl, input bit [31:0] jk,
                                             input bit [31:0] rest);
        entry_item_t e;
        e.pos        = pos;
        e.kind       = kind;
        e.incl       = incl;
        e.join_key   = jk;
        e.src_index  = rest;
        e.align_key  = rest;
        e.dest_index = rest;
        for (int i = 0; i < 4; i++)
        begin
            e.attr[i] = rest;
        end
        return e;
    endfunction

    // Keys lean toward the last held value so that ties reach the later keys.
    function automatic bit [31:0] pick_key(input bit [31:0] base);
        bit [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = base;
            5:             v = base + 32'd1;
            6:             v = base - 32'd1;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = KEY_MIN;
                    1:       v = KEY_MAX;
                    2:       v = 32'd0;
                    default: v = 32'hffff_ffff;
                endcase
            end
            8:             v = $urandom_range(0, 4) - 2;
            default:       v = $urandom;
        endcase
        return v;
    endfunction

    function automatic entry_item_t random_entry(input entry_item_t base, input bit pos);
        entry_item_t e;
        e.pos        = pos;
        e.kind       = ($urandom_range(0, 3) == 0) ? base.kind : 3'($urandom_range(0, 7));
        e.incl       = 1'($urandom_range(0, 1));
        e.join_key   = pick_key(base.join_key);
        e.src_index  = pick_key(base.src_index);
        e.align_key  = pick_key(base.align_key);
        e.dest_index = pick_key(base.dest_index);
        for (int i = 0; i < 4; i++)
        begin
            e.attr[i] = pick_key(base.attr[i]);
        end
        return e;
    endfunction

    task automatic queue_entry(input entry_item_t e);
        pending_entries.push_back(e);
        items_queued++;
        if (e.pos == POS_HOLD)
        begin
            gen_ref = e;
        end
    endtask

    task automatic queue_directed_items();
        // Zero entry against the key extremes and against itself.
        queue_entry(mk_entry(POS_HOLD, KIND_SOURCE, 1'b0, 32'd0, 32'd0));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b0, KEY_MAX, 32'd0));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b0, KEY_MIN, 32'd0));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b0, 32'd0, 32'd0));
        queue_entry(mk_entry(POS_HOLD, KIND_START, 1'b1, KEY_MIN, KEY_MIN));
        queue_entry(mk_entry(POS_COMPARE, KIND_END, 1'b1, KEY_MAX, 32'hffff_ffff));
        queue_entry(mk_entry(POS_COMPARE, KIND_SORT_PAD, 1'b0, KEY_MIN, KEY_MIN));
        // Held sort padding against plain and padded entries.
        queue_entry(mk_entry(POS_HOLD, KIND_SORT_PAD, 1'b1, KEY_MAX, KEY_MAX));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b0, KEY_MIN, KEY_MIN));
        queue_entry(mk_entry(POS_COMPARE, KIND_SORT_PAD, 1'b0, KEY_MIN, KEY_MIN));
        queue_entry(mk_entry(POS_COMPARE, KIND_SORT_PAD, 1'b1, KEY_MAX, KEY_MAX));
        // Equal join keys fall through to the boundary ranks.
        queue_entry(mk_entry(POS_HOLD, KIND_END, 1'b0, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b1, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, KIND_START, 1'b0, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, KIND_END, 1'b1, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, 3'd6, 1'b0, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, KIND_START, 1'b1, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_HOLD, 3'd7, 1'b1, 32'd5, 32'hffff_fff9));
        queue_entry(mk_entry(POS_COMPARE, KIND_DIST_PAD, 1'b1, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, KIND_SOURCE, 1'b0, 32'd5, 32'd7));
        queue_entry(mk_entry(POS_COMPARE, 3'd7, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
    endtask

    // Mostly a hold followed by a few compares; the rest is loose entries.
    task automatic queue_random_items(input int n);
        int made;
        int runs;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                queue_entry(random_entry(gen_ref, POS_HOLD));
                runs = $urandom_range(1, 3);
                for (int i = 0; i < runs; i++)
                begin
                    queue_entry(random_entry(gen_ref, POS_COMPARE));
                end
                made += runs + 1;
            end
            else
            begin
                queue_entry(random_entry(gen_ref, 1'($urandom_range(0, 1))));
                made++;
            end
        end
    endtask

    task automatic write_mode(input mode_t m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_mode = m;
        modes_written[m] = 1'b1;
        mode_writes++;
    endtask

    // Hold entries give no result, so the wait also counts accepted entries, not only results.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (items_accepted != items_queued || expected_less.size() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_proc
        bit fire;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
            begin
                track_entry(drive_entry);
                items_accepted++;
            end
            if (!s_axis_tvalid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_entries.size() > 0)
                begin
                    drive_entry = pending_entries.pop_front();
                    s_axis_tdata <= {{(IN_TDATA_W - IN_USED_W){1'b0}},
                                     drive_entry.attr[3], drive_entry.attr[2],
                                     drive_entry.attr[1], drive_entry.attr[0],
                                     drive_entry.dest_index, drive_entry.align_key,
                                     drive_entry.src_index, drive_entry.join_key,
                                     drive_entry.incl};
                    s_axis_tuser  <= {drive_entry.kind, drive_entry.pos};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_proc
        bit want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_less.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no compare pending",
                                          result_count));
            end
            else
            begin
                want = expected_less.pop_front();
                if (m_axis_tdata[0] !== want)
                begin
                    report_mismatch($sformatf("result %0d: first_less %b, predicted %b",
                                              result_count, m_axis_tdata[0], want));
                end
            end
            result_count++;
        end
    end

    // Receiver back-pressure changes character whenever stall_ticks runs out, picking one of four stall levels.
    always @(posedge clk)
    begin : stall_proc
        if (stall_ticks == 0)
        begin
            stall_level = $urandom_range(0, 3);
            stall_ticks = 64;
        end
        stall_ticks--;
        case (stall_level)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_ticks % 4 != 0);
        endcase
    end

    always @(posedge clk)
    begin : watchdog_proc
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles without a transfer", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stim_proc
        mode_t phase_modes[$];
        phase_modes = {MODE_JOIN_PREC, MODE_PAIRWISE, MODE_END_FIRST, MODE_JOIN_ATTR,
                       MODE_INDEX, MODE_ALIGN, MODE_PAD_LAST, MODE_DEST, MODE_DEST,
                       MODE_JOIN_PREC, MODE_JOIN_ATTR,
                       mode_t'(3'($urandom_range(0, 7)))};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (phase_modes[p])
        begin
            write_mode(phase_modes[p]);
            if (p == 0)
            begin
                queue_directed_items();
            end
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end
        repeat (8) @(posedge clk);
        if (expected_less.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_less.size()));
        end
        $display("tb: %0d entries sent (%0d holds, %0d compares), %0d results checked",
                 items_accepted, hold_count, compare_count, result_count);
        $display("tb: %0d mode writes, modes used %b, %0d mismatches",
                 mode_writes, modes_written, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
